FILE: rtl/qte_pkg.sv
package qte_pkg;

	// quaternion and angle scaling
	localparam int QUAT_FRAC_BITS  = 14;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int CORDIC_STAGES   = 16;

	// port field widths
	localparam int QUAT_W  = 16;
	localparam int ROLL_W  = 16;
	localparam int PITCH_W = 15;
	localparam int YAW_W   = 16;

	// product terms are at most 2^33 in magnitude
	localparam int TW = 36;
	// arcsine argument with 30 fraction bits
	localparam int S30W = 31;
	// square root operand and partial root
	localparam int RW = 2 * S30W;
	localparam int ISQRT_STAGES = S30W;
	localparam int ISQRT_TOP = 2 * (ISQRT_STAGES - 1);

	// shifts that bring 2*QUAT_FRAC_BITS fraction bits to 30
	localparam int S30_SHR = (2 * QUAT_FRAC_BITS >= 30) ? 2 * QUAT_FRAC_BITS - 30 : 0;
	localparam int S30_SHL = (2 * QUAT_FRAC_BITS < 30) ? 30 - 2 * QUAT_FRAC_BITS : 0;

	// angle accumulator, 2^32 per turn
	localparam int ZW = 34;
	localparam int NORM_BIT = 30;
	localparam int RSTEPS = 3;
	localparam int LSTEPS = 5;
	localparam int ATAN_STAGES = 1 + RSTEPS + LSTEPS + CORDIC_STAGES;
	localparam int ATAN_LAT = ATAN_STAGES + 2;

	// degree conversion
	localparam int DEG_W = 11 + ANGLE_FRAC_BITS;
	localparam int PROD_W = ZW + 10 + ANGLE_FRAC_BITS;
	localparam int DEG_SCALE = 360 * (1 << ANGLE_FRAC_BITS);
	localparam int LIM180 = 180 * (1 << ANGLE_FRAC_BITS);
	localparam int LIM90 = 90 * (1 << ANGLE_FRAC_BITS);

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;

	// atan(2^-i) in units of 2^32 per turn
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'h20000000;
			1: v = 32'h12E4051E;
			2: v = 32'h09FB385B;
			3: v = 32'h051111D4;
			4: v = 32'h028B0D43;
			5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;
			7: v = 32'h00517C55;
			8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	// classified item handed from front to back
	typedef struct packed {
		logic signed [TW-1:0]   sr;
		logic signed [TW-1:0]   cr;
		logic signed [TW-1:0]   sy;
		logic signed [TW-1:0]   cy;
		logic signed [S30W-1:0] s30;
		logic                   clamp;
		logic                   sneg;
	} qte_work_t;

	typedef struct packed {
		logic clamp;
		logic sneg;
	} qte_flag_t;

endpackage

FILE: rtl/qte_quat_if.sv
interface qte_quat_if;
	logic valid;
	logic ready;
	logic signed [qte_pkg::QUAT_W-1:0] quat_w;
	logic signed [qte_pkg::QUAT_W-1:0] quat_x;
	logic signed [qte_pkg::QUAT_W-1:0] quat_y;
	logic signed [qte_pkg::QUAT_W-1:0] quat_z;

	modport source(output valid, output quat_w, output quat_x, output quat_y, output quat_z,
		input ready);
	modport sink(input valid, input quat_w, input quat_x, input quat_y, input quat_z,
		output ready);
endinterface

FILE: rtl/qte_euler_if.sv
interface qte_euler_if;
	logic valid;
	logic ready;
	logic signed [qte_pkg::ROLL_W-1:0]  roll_deg;
	logic signed [qte_pkg::PITCH_W-1:0] pitch_deg;
	logic signed [qte_pkg::YAW_W-1:0]   yaw_deg;
	logic                               pitch_clamped;

	modport source(output valid, output roll_deg, output pitch_deg, output yaw_deg,
		output pitch_clamped, input ready);
	modport sink(input valid, input roll_deg, input pitch_deg, input yaw_deg,
		input pitch_clamped, output ready);
endinterface

FILE: rtl/qte_front.sv
module qte_front (
	input  logic              clk,
	input  logic              arst_n,
	qte_quat_if.sink          quat,
	input  logic              full,
	output logic              push,
	output qte_pkg::qte_work_t work
);

	localparam logic signed [qte_pkg::TW-1:0] ONE =
		qte_pkg::TW'(1) <<< (2 * qte_pkg::QUAT_FRAC_BITS);

	logic en;
	logic vld_s1, vld_s2;
	logic signed [2*qte_pkg::QUAT_W-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1;
	logic signed [2*qte_pkg::QUAT_W-1:0] wz_s1, xy_s1, zz_s1;
	qte_pkg::qte_work_t work_s2, work_d;
	logic signed [qte_pkg::TW-1:0] sp, sabs;

	// stall only when a finished item cannot enter the queue
	assign en = !(vld_s2 && full);
	assign quat.ready = en;
	assign push = vld_s2 && !full;
	assign work = work_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= quat.valid;
			vld_s2 <= vld_s1;
		end
	end

	// product terms
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= quat.quat_w * quat.quat_x;
			yz_s1 <= quat.quat_y * quat.quat_z;
			xx_s1 <= quat.quat_x * quat.quat_x;
			yy_s1 <= quat.quat_y * quat.quat_y;
			wy_s1 <= quat.quat_w * quat.quat_y;
			zx_s1 <= quat.quat_z * quat.quat_x;
			wz_s1 <= quat.quat_w * quat.quat_z;
			xy_s1 <= quat.quat_x * quat.quat_y;
			zz_s1 <= quat.quat_z * quat.quat_z;
		end
	end

	// sums, clamp classification and arcsine argument
	always_comb begin
		work_d.sr = (qte_pkg::TW'(wx_s1) + qte_pkg::TW'(yz_s1)) <<< 1;
		work_d.cr = ONE - ((qte_pkg::TW'(xx_s1) + qte_pkg::TW'(yy_s1)) <<< 1);
		work_d.sy = (qte_pkg::TW'(wz_s1) + qte_pkg::TW'(xy_s1)) <<< 1;
		work_d.cy = ONE - ((qte_pkg::TW'(yy_s1) + qte_pkg::TW'(zz_s1)) <<< 1);
		sp = (qte_pkg::TW'(wy_s1) - qte_pkg::TW'(zx_s1)) <<< 1;
		sabs = (sp < 0) ? -sp : sp;
		work_d.clamp = (sabs >= ONE);
		work_d.sneg = (sp < 0);
		work_d.s30 = work_d.clamp ? '0 :
			qte_pkg::S30W'((sp >>> qte_pkg::S30_SHR) <<< qte_pkg::S30_SHL);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s2 <= work_d;
		end
	end

endmodule

FILE: rtl/qte_fifo.sv
module qte_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  qte_pkg::qte_work_t wdata,
	input  logic               pop,
	output qte_pkg::qte_work_t rdata,
	output logic               full,
	output logic               empty
);

	qte_pkg::qte_work_t mem [qte_pkg::FIFO_DEPTH];
	logic [qte_pkg::FIFO_AW-1:0] wptr_q, rptr_q;
	logic [qte_pkg::FIFO_AW:0]   cnt_q;

	assign full = (cnt_q == qte_pkg::FIFO_AW'(0) + (qte_pkg::FIFO_AW+1)'(qte_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= wdata;
		end
	end

endmodule

FILE: rtl/qte_isqrt.sv
module qte_isqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [qte_pkg::RW-1:0]     n,
	output logic [qte_pkg::S30W-1:0]   root
);

	localparam int NS = qte_pkg::ISQRT_STAGES;

	logic [qte_pkg::RW-1:0] rem_q [NS];
	logic [qte_pkg::RW-1:0] res_q [NS];
	logic [qte_pkg::RW-1:0] rem_d [NS];
	logic [qte_pkg::RW-1:0] res_d [NS];

	assign root = res_q[NS-1][qte_pkg::S30W-1:0];

	// one result bit per stage, restoring method
	always_comb begin
		logic [qte_pkg::RW-1:0] rp, sp, bitv, trial;
		for (int i = 0; i < NS; i++) begin
			rp = (i == 0) ? n : rem_q[(i == 0) ? 0 : i - 1];
			sp = (i == 0) ? '0 : res_q[(i == 0) ? 0 : i - 1];
			bitv = qte_pkg::RW'(1) << (qte_pkg::ISQRT_TOP - 2 * i);
			trial = sp + bitv;
			if (rp >= trial) begin
				rem_d[i] = rp - trial;
				res_d[i] = (sp >> 1) + bitv;
			end else begin
				rem_d[i] = rp;
				res_d[i] = sp >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NS; i++) begin
				rem_q[i] <= rem_d[i];
				res_q[i] <= res_d[i];
			end
		end
	end

endmodule

FILE: rtl/qte_atan2.sv
module qte_atan2 (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [qte_pkg::TW-1:0]     y,
	input  logic signed [qte_pkg::TW-1:0]     x,
	output logic signed [qte_pkg::DEG_W-1:0]  deg
);

	localparam int NS = qte_pkg::ATAN_STAGES;
	localparam int RS = qte_pkg::RSTEPS;
	localparam int LS = qte_pkg::LSTEPS;
	localparam logic signed [qte_pkg::ZW-1:0] HALF = qte_pkg::ZW'(1) <<< 31;
	localparam logic [qte_pkg::TW-1:0] LIM = qte_pkg::TW'(1) << qte_pkg::NORM_BIT;
	localparam logic signed [qte_pkg::PROD_W-1:0] SCALE =
		qte_pkg::PROD_W'(qte_pkg::DEG_SCALE);
	localparam logic signed [qte_pkg::PROD_W-1:0] RND = qte_pkg::PROD_W'(1) <<< 31;

	logic signed [qte_pkg::TW-1:0] x_q [NS];
	logic signed [qte_pkg::TW-1:0] y_q [NS];
	logic signed [qte_pkg::ZW-1:0] z_q [NS];
	logic                          zf_q [NS];
	logic signed [qte_pkg::TW-1:0] x_d [NS];
	logic signed [qte_pkg::TW-1:0] y_d [NS];
	logic signed [qte_pkg::ZW-1:0] z_d [NS];
	logic                          zf_d [NS];
	logic signed [qte_pkg::PROD_W-1:0] prod_s1;
	logic signed [qte_pkg::PROD_W-1:0] rnd;

	function automatic logic [qte_pkg::TW-1:0] mag(
		input logic signed [qte_pkg::TW-1:0] a,
		input logic signed [qte_pkg::TW-1:0] b
	);
		logic [qte_pkg::TW-1:0] ma, mb;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		return (ma > mb) ? ma : mb;
	endfunction

	// quadrant fold, normalization steps, then rotation stages
	always_comb begin
		logic [qte_pkg::TW-1:0] m;
		logic signed [qte_pkg::TW-1:0] px, py, xs, ys;
		int sh;
		int ci;
		x_d[0] = x;
		y_d[0] = y;
		z_d[0] = '0;
		zf_d[0] = (x == 0) && (y == 0);
		if (x < 0) begin
			x_d[0] = -x;
			y_d[0] = -y;
			z_d[0] = (y >= 0) ? HALF : -HALF;
		end
		for (int k = 1; k < NS; k++) begin
			px = x_q[k-1];
			py = y_q[k-1];
			x_d[k] = px;
			y_d[k] = py;
			z_d[k] = z_q[k-1];
			zf_d[k] = zf_q[k-1];
			m = mag(px, py);
			if (k <= RS) begin
				// halve while too large
				if (m >= LIM) begin
					x_d[k] = px >>> 1;
					y_d[k] = py >>> 1;
				end
			end else if (k <= RS + LS) begin
				// binary search for the doubling count
				sh = 1 << (RS + LS - k);
				if (m < (qte_pkg::TW'(1) << (qte_pkg::NORM_BIT - sh))) begin
					x_d[k] = px <<< sh;
					y_d[k] = py <<< sh;
				end
			end else begin
				ci = k - 1 - RS - LS;
				xs = px >>> ci;
				ys = py >>> ci;
				if (py >= 0) begin
					x_d[k] = px + ys;
					y_d[k] = py - xs;
					z_d[k] = z_q[k-1] + qte_pkg::ZW'(qte_pkg::atan_turn(ci));
				end else begin
					x_d[k] = px - ys;
					y_d[k] = py + xs;
					z_d[k] = z_q[k-1] - qte_pkg::ZW'(qte_pkg::atan_turn(ci));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NS; k++) begin
				x_q[k] <= x_d[k];
				y_q[k] <= y_d[k];
				z_q[k] <= z_d[k];
				zf_q[k] <= zf_d[k];
			end
		end
	end

	// turns to degree counts, rounded
	assign rnd = (prod_s1 + RND) >>> 32;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= zf_q[NS-1] ? '0 : qte_pkg::PROD_W'(z_q[NS-1]) * SCALE;
			deg <= rnd[qte_pkg::DEG_W-1:0];
		end
	end

endmodule

FILE: rtl/qte_back.sv
module qte_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	output logic               pop,
	input  qte_pkg::qte_work_t work,
	qte_euler_if.source        euler
);

	localparam int NI = qte_pkg::ISQRT_STAGES;
	localparam int NA = qte_pkg::ATAN_LAT;
	localparam logic [qte_pkg::RW-1:0] ONE60 = qte_pkg::RW'(1) << qte_pkg::ISQRT_TOP;
	localparam logic signed [qte_pkg::DEG_W-1:0] L180 = qte_pkg::DEG_W'(qte_pkg::LIM180);
	localparam logic signed [qte_pkg::DEG_W-1:0] L90 = qte_pkg::DEG_W'(qte_pkg::LIM90);

	logic en;
	logic vld_s1;
	qte_pkg::qte_work_t work_s1;
	logic signed [qte_pkg::RW-1:0] sq_w;
	logic [qte_pkg::RW-1:0] sq_s1;
	logic [qte_pkg::S30W-1:0] root;

	qte_pkg::qte_work_t side_q [NI];
	logic               sv_q [NI];
	qte_pkg::qte_flag_t flag_q [NA];
	logic               fv_q [NA];

	logic signed [qte_pkg::DEG_W-1:0] roll_d, pitch_d, yaw_d;
	logic signed [qte_pkg::DEG_W-1:0] roll_n, pitch_n, yaw_n;
	qte_pkg::qte_work_t side_last;

	function automatic logic signed [qte_pkg::DEG_W-1:0] sat_deg(
		input logic signed [qte_pkg::DEG_W-1:0] d,
		input logic signed [qte_pkg::DEG_W-1:0] lim
	);
		if (d > lim) begin
			return lim;
		end else if (d < -lim) begin
			return -lim;
		end
		return d;
	endfunction

	// whole back pipeline moves when the output register can take a transfer
	assign en = !euler.valid || euler.ready;
	assign pop = !empty && en;
	assign sq_w = work.s30 * work.s30;
	assign side_last = side_q[NI-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < NI; i++) begin
				sv_q[i] <= 1'b0;
			end
			for (int i = 0; i < NA; i++) begin
				fv_q[i] <= 1'b0;
			end
			euler.valid <= 1'b0;
		end else if (en) begin
			vld_s1 <= pop;
			sv_q[0] <= vld_s1;
			for (int i = 1; i < NI; i++) begin
				sv_q[i] <= sv_q[i-1];
			end
			fv_q[0] <= sv_q[NI-1];
			for (int i = 1; i < NA; i++) begin
				fv_q[i] <= fv_q[i-1];
			end
			euler.valid <= fv_q[NA-1];
		end
	end

	// square of the arcsine argument and payload delay lines
	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work;
			sq_s1 <= sq_w;
			side_q[0] <= work_s1;
			for (int i = 1; i < NI; i++) begin
				side_q[i] <= side_q[i-1];
			end
			flag_q[0] <= '{clamp: side_last.clamp, sneg: side_last.sneg};
			for (int i = 1; i < NA; i++) begin
				flag_q[i] <= flag_q[i-1];
			end
		end
	end

	// cosine of pitch as a square root
	qte_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.n    (ONE60 - sq_s1),
		.root (root)
	);

	qte_atan2 u_roll (
		.clk (clk),
		.en  (en),
		.y   (side_last.sr),
		.x   (side_last.cr),
		.deg (roll_d)
	);

	qte_atan2 u_pitch (
		.clk (clk),
		.en  (en),
		.y   (qte_pkg::TW'(side_last.s30)),
		.x   (signed'(qte_pkg::TW'(root))),
		.deg (pitch_d)
	);

	qte_atan2 u_yaw (
		.clk (clk),
		.en  (en),
		.y   (side_last.sy),
		.x   (side_last.cy),
		.deg (yaw_d)
	);

	// saturation and clamp select
	always_comb begin
		roll_n = sat_deg(roll_d, L180);
		yaw_n = sat_deg(yaw_d, L180);
		if (flag_q[NA-1].clamp) begin
			pitch_n = flag_q[NA-1].sneg ? -L90 : L90;
		end else begin
			pitch_n = sat_deg(pitch_d, L90);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			euler.roll_deg <= roll_n[qte_pkg::ROLL_W-1:0];
			euler.pitch_deg <= pitch_n[qte_pkg::PITCH_W-1:0];
			euler.yaw_deg <= yaw_n[qte_pkg::YAW_W-1:0];
			euler.pitch_clamped <= flag_q[NA-1].clamp;
		end
	end

endmodule

FILE: rtl/quaternion_to_euler_angles.sv
// quaternion to roll, pitch and yaw in degrees, 128 counts per degree
// throughput: one quaternion per cycle; front and back each hold on their own
// a four-entry queue sits between the sum stage and the square-root stage
// reset: arst_n clears all valid bits and the queue, payload registers keep no reset
module quaternion_to_euler_angles (
	input  logic        clk,
	input  logic        arst_n,
	qte_quat_if.sink    quat,
	qte_euler_if.source euler
);

	logic push, pop, full, empty;
	qte_pkg::qte_work_t wdata, rdata;

	// products, sums and clamp classification
	qte_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.quat   (quat),
		.full   (full),
		.push   (push),
		.work   (wdata)
	);

	qte_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.full   (full),
		.empty  (empty)
	);

	// square root, three cordic units and output register
	qte_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.pop    (pop),
		.work   (rdata),
		.euler  (euler)
	);

endmodule
